[rtl/core/sblr_pkg.sv]
`default_nettype none
package sblr_pkg;

  localparam int unsigned SblrNumBands     = 12;
  localparam int unsigned SblrLedsPerBar   = 24;
  localparam int unsigned SblrAverageFrames = 4;

  localparam int unsigned EnergyW   = 32;
  localparam int unsigned FullW     = 20;
  localparam int unsigned ColourW   = 24;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned DivW      = 32;
  localparam int unsigned DivCntW   = 5;

  localparam logic [ColourW-1:0] ColourRst = 24'h00FF00;

endpackage
`default_nettype wire

[rtl/core/sblr_ram.sv]
`default_nettype none
module sblr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 12,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/spectrum_bar_led_renderer.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tdata: band_energy, full_scale
// m_axis    out  m_axis_tvalid/tready         tdata: pixel_colour, tlast, tuser
// cfg       in   cfg_we (no wait)             cfg_wdata: bar_colour
//
// A band word is loaded and runs through the 32-step shared radix-2 divider for its average and
// level, then gives one pixel per cycle unless stalled (LEDS_PER_BAR, one less for band 0).
// full_scale / LEDS_PER_BAR is a reciprocal multiply in the load cycle.
// The level divide step is skipped when full_scale / LEDS_PER_BAR is zero.
// Reset clears control state and the per-band valid bits; unwritten averages read as zero.
// A stalled output holds the pixel register; a new band word is taken while the last pixel waits.
`default_nettype none
module spectrum_bar_led_renderer
  import sblr_pkg::*;
#(
  parameter int unsigned NUM_BANDS      = SblrNumBands,
  parameter int unsigned LEDS_PER_BAR   = SblrLedsPerBar,
  parameter int unsigned AVERAGE_FRAMES = SblrAverageFrames
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [31:0] band_energy, [51:32] full_scale, [55:52] zero
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [23:0] pixel_colour
  output logic      [OutTdataW-1:0] m_axis_tdata_o,
  output logic                      m_axis_tlast_o,
  // [0] last_of_frame
  output logic                      m_axis_tuser_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [ColourW-1:0]   cfg_wdata_i
);

  localparam int unsigned BandW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int unsigned LvlW  = $clog2(LEDS_PER_BAR + 1);
  localparam int unsigned FrW   = $clog2(AVERAGE_FRAMES + 1);
  localparam int unsigned StepShift = FullW + LvlW;
  localparam int unsigned ProdW     = FullW + StepShift;

  localparam logic [LvlW-1:0]  LedsL     = LvlW'(LEDS_PER_BAR);
  localparam logic [BandW-1:0] LastBandL = BandW'(NUM_BANDS - 1);
  localparam logic [FrW-1:0]   AvgFrL    = FrW'(AVERAGE_FRAMES);
  localparam logic [StepShift-1:0] StepRecip =
    StepShift'(((64'd1 << StepShift) + 64'(LEDS_PER_BAR) - 64'd1) / 64'(LEDS_PER_BAR));

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_AVG  = 5'b00100,
    ST_LVL  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [ColourW-1:0]  colour_q, colour_d;
  logic [BandW-1:0]    band_pos_q, band_pos_d;
  logic [FrW-1:0]      frames_q, frames_d;
  logic [NUM_BANDS-1:0] valid_q, valid_d;
  logic [BandW-1:0]    band_q, band_d;
  logic [EnergyW-1:0]  energy_q, energy_d;
  logic [FullW-1:0]    full_q, full_d;
  logic [FullW-1:0]    step_q, step_d;
  logic [LvlW-1:0]     level_q, level_d;
  logic [LvlW-1:0]     idx_q, idx_d;
  logic [DivW-1:0]     dvd_q, dvd_d;
  logic [DivW-1:0]     dvs_q, dvs_d;
  logic [DivW-1:0]     rem_q, rem_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [ColourW-1:0]  out_colour_q, out_colour_d;
  logic                out_last_q, out_last_d;
  logic                out_frame_q, out_frame_d;

  logic                in_acc;
  logic                ram_we;
  logic [DivW-1:0]     ram_rdata;
  logic [DivW-1:0]     avg_old;
  logic [ProdW-1:0]    step_prod;
  logic [DivW:0]       shifted;
  logic [DivW:0]       trial;
  logic [DivW-1:0]     rem_nx;
  logic [DivW-1:0]     dvd_nx;
  logic                div_last;
  logic [LvlW-1:0]     leds;
  logic [DivW-1:0]     lvl_src;
  logic [LvlW-1:0]     lvl_cap;
  logic                out_load;
  logic                pix_lit;
  logic                pix_last;
  logic                band_last;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  assign avg_old   = valid_q[band_q] ? ram_rdata : '0;
  assign step_prod = ProdW'(full_q) * ProdW'(StepRecip);
  assign shifted   = {rem_q, dvd_q[DivW-1]};
  assign trial     = shifted - {1'b0, dvs_q};
  assign rem_nx    = trial[DivW] ? shifted[DivW-1:0] : trial[DivW-1:0];
  assign dvd_nx    = {dvd_q[DivW-2:0], ~trial[DivW]};
  assign div_last  = &cnt_q;

  assign leds      = (band_q == '0) ? LedsL - LvlW'(1) : LedsL;
  assign band_last = (band_q == LastBandL);
  assign lvl_src   = (state_q == ST_AVG) ? DivW'(LEDS_PER_BAR) : dvd_nx;
  assign lvl_cap   = (lvl_src > DivW'(leds)) ? leds : lvl_src[LvlW-1:0];
  assign pix_lit   = band_q[0] ? (idx_q >= leds - level_q) : (idx_q < level_q);
  assign pix_last  = (idx_q == leds - LvlW'(1));
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);
  assign ram_we    = (state_q == ST_AVG) && div_last;

  always_comb begin
    state_d      = state_q;
    colour_d     = cfg_we_i ? cfg_wdata_i : colour_q;
    band_pos_d   = band_pos_q;
    frames_d     = frames_q;
    valid_d      = valid_q;
    band_d       = band_q;
    energy_d     = energy_q;
    full_d       = full_q;
    step_d       = step_q;
    level_d      = level_q;
    idx_d        = idx_q;
    dvd_d        = dvd_nx;
    dvs_d        = dvs_q;
    rem_d        = rem_nx;
    cnt_d        = cnt_q + DivCntW'(1);
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_colour_d = out_colour_q;
    out_last_d   = out_last_q;
    out_frame_d  = out_frame_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          energy_d = s_axis_tdata_i[EnergyW-1:0];
          full_d   = s_axis_tdata_i[EnergyW +: FullW];
          band_d   = band_pos_q;
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        step_d  = step_prod[StepShift +: FullW];
        dvd_d   = avg_old * DivW'(frames_q - FrW'(1)) + energy_q;
        dvs_d   = DivW'(frames_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_AVG;
      end
      ST_AVG: begin
        if (div_last) begin
          valid_d[band_q] = 1'b1;
          if (step_q == '0) begin
            level_d = lvl_cap;
            idx_d   = '0;
            state_d = ST_EMIT;
          end else begin
            dvd_d   = dvd_nx;
            dvs_d   = DivW'(step_q);
            rem_d   = '0;
            cnt_d   = '0;
            state_d = ST_LVL;
          end
        end
      end
      ST_LVL: begin
        if (div_last) begin
          level_d = lvl_cap;
          idx_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_colour_d = pix_lit ? colour_q : '0;
          out_last_d   = pix_last;
          out_frame_d  = pix_last && band_last;
          idx_d        = idx_q + LvlW'(1);
          if (pix_last) begin
            state_d = ST_IDLE;
            if (band_last) begin
              band_pos_d = '0;
              if (frames_q < AvgFrL) begin
                frames_d = frames_q + FrW'(1);
              end
            end else begin
              band_pos_d = band_q + BandW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      colour_q    <= ColourRst;
      band_pos_q  <= '0;
      frames_q    <= FrW'(1);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      colour_q    <= colour_d;
      band_pos_q  <= band_pos_d;
      frames_q    <= frames_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    band_q       <= band_d;
    energy_q     <= energy_d;
    full_q       <= full_d;
    step_q       <= step_d;
    level_q      <= level_d;
    idx_q        <= idx_d;
    dvd_q        <= dvd_d;
    dvs_q        <= dvs_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    out_colour_q <= out_colour_d;
    out_last_q   <= out_last_d;
    out_frame_q  <= out_frame_d;
  end

  sblr_ram #(
    .WIDTH (DivW),
    .DEPTH (NUM_BANDS),
    .AW    (BandW)
  ) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (band_q),
    .wdata_i (dvd_nx),
    .re_i    (in_acc),
    .raddr_i (band_pos_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_colour_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_frame_q;

  a_frame_implies_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("last_of_frame without last_of_band");

  a_frames_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q != '0 && frames_q <= AvgFrL)
    else $error("frame count out of range");

  a_frame_end_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o |-> band_pos_q == '0)
    else $error("band position not rewound at frame end");

  a_level_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> level_q <= leds)
    else $error("bar level exceeds strip length");

endmodule
`default_nettype wire
